// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the hex line entry parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/hlep_pkg.sv =====
// Types, character codes and the character decoder of the hex line entry parser.
package hlep_pkg;

  localparam logic [7:0] CH_CTRLC = 8'h03;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] LETTER_BIAS = 8'h37;

  localparam logic [1:0] STAT_PENDING = 2'd0;
  localparam logic [1:0] STAT_VALUE   = 2'd1;
  localparam logic [1:0] STAT_CANCEL  = 2'd2;

  localparam int VALUE_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PACK,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    K_CTRLC,
    K_NEWLINE,
    K_BS,
    K_HEX,
    K_OTHER
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [3:0] nib;
    logic [7:0] upper;
  } char_dec_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic step;
  } buf_ctl_t;

  function automatic char_dec_t decode_char(logic [7:0] b);
    char_dec_t d;
    logic [7:0] u;
    logic [7:0] dig;
    logic [7:0] ltr;
    u = (b >= CH_LO_A && b <= CH_LO_Z) ? b - CASE_OFFSET : b;
    dig = u - CH_ZERO;
    ltr = u - LETTER_BIAS;
    d.upper = u;
    d.nib = 4'd0;
    if (b == CH_CTRLC) begin
      d.kind = K_CTRLC;
    end else if (b == CH_CR || b == CH_LF) begin
      d.kind = K_NEWLINE;
    end else if (b == CH_BS) begin
      d.kind = K_BS;
    end else if (u >= CH_ZERO && u <= CH_NINE) begin
      d.kind = K_HEX;
      d.nib = dig[3:0];
    end else if (u >= CH_UP_A && u <= CH_UP_F) begin
      d.kind = K_HEX;
      d.nib = ltr[3:0];
    end else begin
      d.kind = K_OTHER;
    end
    return d;
  endfunction

endpackage

// ===== rtl/hlep_char_if.sv =====
// Channel that carries one received terminal character per transaction.
interface hlep_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/hlep_result_if.sv =====
// Channel that carries one parser result per transaction.
interface hlep_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] value;
  logic        echo_valid;
  logic [7:0]  echo_byte;
  logic        last;

  modport source (output valid, output status, output value, output echo_valid,
                  output echo_byte, output last, input ready);
  modport sink (input valid, input status, input value, input echo_valid,
                input echo_byte, input last, output ready);
endinterface

// ===== rtl/hlep_digit_buf.sv =====
// Digit store and the shift-accumulate unit that packs digits into a value.
module hlep_digit_buf
  import hlep_pkg::*;
#(
  parameter int MAX_DIGITS = 5,
  parameter int IDX_W = 3
) (
  input  logic               clk,
  input  buf_ctl_t           ctl,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [3:0]         wr_nib,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic [VALUE_W-1:0] acc
);

  logic [3:0] store [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      store[wr_idx] <= wr_nib;
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.step) begin
      acc <= {acc[VALUE_W-5:0], store[rd_idx]};
    end
  end

endmodule

// ===== rtl/hex_line_entry_parser_core.sv =====
// Top level of the hex line entry parser: character decode, sequencer and result register.
// A character's first result is offered in the cycle after its transaction, but a newline
// with stored digits first walks them in ST_PACK, one per cycle, before its result comes.
// A backspace on a non-empty buffer offers three results in turn. No new character is taken
// until the last result of the one before it has been taken.
// Reset clears the digit count and the sequencer; the digit store itself is not cleared.
`include "assert_macros.svh"

module hex_line_entry_parser_core
  import hlep_pkg::*;
#(
  parameter int MAX_DIGITS = 5
) (
  input  logic           clk,
  input  logic           rst,
  hlep_char_if.sink      char_ch,
  hlep_result_if.source  result_ch
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] walk_idx;
  logic [CNT_W-1:0] walk_idx_inc;
  logic [1:0]       bs_left;
  logic [1:0]       status;
  logic             echo_valid;
  logic [7:0]       echo_byte;
  logic             last;
  char_dec_t        dec;
  buf_ctl_t         buf_ctl;
  logic             in_fire;
  logic             out_fire;
  logic             full;

  assign dec = decode_char(char_ch.rx_byte);
  assign in_fire = char_ch.valid && char_ch.ready;
  assign out_fire = result_ch.valid && result_ch.ready;
  assign full = (count == CNT_W'(MAX_DIGITS));
  assign walk_idx_inc = walk_idx + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (dec.kind == K_NEWLINE && count != '0) begin
            state_next = ST_PACK;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_PACK: begin
        if (walk_idx_inc == count) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire && bs_left == 2'd0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    char_ch.ready = 1'b0;
    result_ch.valid = 1'b0;
    buf_ctl = '0;
    unique case (state)
      ST_IDLE: begin
        char_ch.ready = 1'b1;
        buf_ctl.clr = in_fire;
        buf_ctl.wr = in_fire && dec.kind == K_HEX && !full;
      end
      ST_PACK: begin
        buf_ctl.step = 1'b1;
      end
      ST_OUT: begin
        result_ch.valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      bs_left <= 2'd0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        walk_idx <= '0;
        bs_left <= 2'd0;
        status <= STAT_PENDING;
        echo_valid <= 1'b1;
        echo_byte <= CH_BELL;
        last <= 1'b1;
        case (dec.kind)
          K_CTRLC: begin
            status <= STAT_CANCEL;
            echo_valid <= 1'b0;
            echo_byte <= 8'h00;
          end
          K_NEWLINE: begin
            status <= STAT_VALUE;
            echo_valid <= 1'b0;
            echo_byte <= 8'h00;
          end
          K_BS: begin
            if (count != '0) begin
              count <= count - 1'b1;
              echo_byte <= CH_BS;
              last <= 1'b0;
              bs_left <= 2'd2;
            end
          end
          K_HEX: begin
            if (!full) begin
              count <= count + 1'b1;
              echo_byte <= dec.upper;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_PACK) begin
        walk_idx <= walk_idx_inc;
        if (walk_idx_inc == count) begin
          count <= '0;
        end
      end
      if (state == ST_OUT && out_fire && bs_left != 2'd0) begin
        bs_left <= bs_left - 1'b1;
        echo_byte <= (bs_left == 2'd2) ? CH_SPACE : CH_BS;
        last <= (bs_left == 2'd1);
      end
    end
  end

  hlep_digit_buf #(
    .MAX_DIGITS(MAX_DIGITS),
    .IDX_W(IDX_W)
  ) u_digit_buf (
    .clk(clk),
    .ctl(buf_ctl),
    .wr_idx(count[IDX_W-1:0]),
    .wr_nib(dec.nib),
    .rd_idx(walk_idx[IDX_W-1:0]),
    .acc(result_ch.value)
  );

  assign result_ch.status = status;
  assign result_ch.echo_valid = echo_valid;
  assign result_ch.echo_byte = echo_byte;
  assign result_ch.last = last;

  `ASSERT_ALWAYS(a_count_max, count <= CNT_W'(MAX_DIGITS), "digit count above capacity")
  `ASSERT_IMPLIES(a_walk_in_range, state == ST_PACK, walk_idx < count, "walk past digits")
  `ASSERT_IMPLIES(a_value_clears, result_ch.valid && status == STAT_VALUE, count == '0,
                  "buffer not emptied after newline")
  `ASSERT_NEXT(a_one_at_a_time, in_fire, !char_ch.ready, "input taken while busy")

endmodule

// ===== tb/hlep_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the hex line entry parser: predicts results from accepted characters and compares.
module hlep_result_checker
  import hlep_pkg::*;
#(
  parameter int MAX_DIGITS = 5
) (
  input  logic   clk,
  input  logic   rst,
  hlep_char_if   char_ch,
  hlep_result_if result_ch,
  output int     fail_count,
  output int     outstanding
);

  typedef struct {
    logic [1:0]  status;
    logic [15:0] value;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        last;
  } parser_result_t;

  parser_result_t expected_results[$];
  logic [3:0]     digits[MAX_DIGITS];
  int             digit_count;

  initial begin
    fail_count = 0;
  end

  task automatic report_fail(input string msg);
    $display("%0t: hlep mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp);
    if (got !== exp) begin
      report_fail($sformatf("%s is %0h, expected %0h", name, got, exp));
    end
  endtask

  task automatic push_result(input logic [1:0] status, input logic [15:0] value,
                             input logic echo_valid, input logic [7:0] echo_byte,
                             input logic last);
    parser_result_t r;
    r.status = status;
    r.value = value;
    r.echo_valid = echo_valid;
    r.echo_byte = echo_byte;
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_char(input logic [7:0] b);
    logic [7:0]  u;
    logic [7:0]  offset;
    logic [15:0] packed_val;
    logic        is_hex;
    int          i;
    if (b == CH_CTRLC) begin
      push_result(STAT_CANCEL, 16'h0, 1'b0, 8'h00, 1'b1);
    end else if (b == CH_CR || b == CH_LF) begin
      packed_val = 16'h0;
      for (i = 0; i < digit_count; i++) begin
        packed_val = {packed_val[11:0], digits[i]};
      end
      digit_count = 0;
      push_result(STAT_VALUE, packed_val, 1'b0, 8'h00, 1'b1);
    end else if (b == CH_BS) begin
      if (digit_count == 0) begin
        push_result(STAT_PENDING, 16'h0, 1'b1, CH_BELL, 1'b1);
      end else begin
        digit_count--;
        push_result(STAT_PENDING, 16'h0, 1'b1, CH_BS, 1'b0);
        push_result(STAT_PENDING, 16'h0, 1'b1, CH_SPACE, 1'b0);
        push_result(STAT_PENDING, 16'h0, 1'b1, CH_BS, 1'b1);
      end
    end else begin
      u = (b >= CH_LO_A && b <= CH_LO_Z) ? b - CASE_OFFSET : b;
      is_hex = 1'b1;
      offset = 8'h00;
      if (u >= CH_ZERO && u <= CH_NINE) begin
        offset = u - CH_ZERO;
      end else if (u >= CH_UP_A && u <= CH_UP_F) begin
        offset = u - CH_UP_A + 8'd10;
      end else begin
        is_hex = 1'b0;
      end
      if (!is_hex || digit_count >= MAX_DIGITS) begin
        push_result(STAT_PENDING, 16'h0, 1'b1, CH_BELL, 1'b1);
      end else begin
        digits[digit_count] = offset[3:0];
        digit_count++;
        push_result(STAT_PENDING, 16'h0, 1'b1, u, 1'b1);
      end
    end
  endtask

  task automatic compare_result();
    parser_result_t exp;
    if (expected_results.size() == 0) begin
      report_fail($sformatf("result with nothing expected, echo %0h status %0d",
                            result_ch.echo_byte, result_ch.status));
    end else begin
      exp = expected_results.pop_front();
      check_field("status", 16'(result_ch.status), 16'(exp.status));
      check_field("value", result_ch.value, exp.value);
      check_field("echo_valid", 16'(result_ch.echo_valid), 16'(exp.echo_valid));
      check_field("echo_byte", 16'(result_ch.echo_byte), 16'(exp.echo_byte));
      check_field("last", 16'(result_ch.last), 16'(exp.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      digit_count = 0;
      outstanding <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        compare_result();
      end
      if (char_ch.valid && char_ch.ready) begin
        predict_char(char_ch.rx_byte);
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== tb/hex_line_entry_parser_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the hex line entry parser: clock, reset, character stimulus and verdict.
module hex_line_entry_parser_core_tb
  import hlep_pkg::*;
();

  localparam int MAX_DIGITS = 5;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 102;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_requests;
  int   chars_sent;
  int   fail_count;
  int   outstanding;
  int   quiet_cycles;

  hlep_char_if   char_ch();
  hlep_result_if result_ch();

  hex_line_entry_parser_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .char_ch(char_ch),
    .result_ch(result_ch)
  );

  hlep_result_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) result_checker (
    .clk(clk),
    .rst(rst),
    .char_ch(char_ch),
    .result_ch(result_ch),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL hex_line_entry_parser_core");
    $finish;
  end

  initial begin
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid <= 1'b1;
    char_ch.rx_byte <= b;
    do @(posedge clk); while (!char_ch.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [7:0] random_hex_char();
    logic [7:0] n;
    n = 8'($urandom_range(15));
    if (n < 8'd10) begin
      return CH_ZERO + n;
    end
    return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + n - 8'd10;
  endfunction

  task automatic send_line();
    int         n;
    int         k;
    int         pick;
    logic [7:0] noise;
    n = $urandom_range(MAX_DIGITS + 2);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      noise = 8'($urandom_range(255));
      if (pick < 10) begin
        send_char(CH_BS);
      end else if (pick < 14) begin
        send_char(CH_CTRLC);
      end else if (pick < 24) begin
        send_char(noise);
      end else begin
        send_char(random_hex_char());
      end
    end
    send_char($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    if (with_hold) begin
      hold_requests <= hold_requests + 1;
    end
    chars_sent = 0;
    while (chars_sent < ITEMS_PER_PHASE) begin
      send_line();
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    char_ch.valid <= 1'b0;
    char_ch.rx_byte <= 8'h00;
    send_idle_pct = 11;
    recv_idle_pct <= 78;
    hold_requests <= 0;
    chars_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A full buffer rejects digits but still honors cancel, backspace and newline.
    send_text("09afAF");
    send_char(CH_CTRLC);
    send_char(CH_BS);
    send_text("b");
    send_char(CH_CR);
    send_char(CH_BS);
    send_text("g/:@z");
    send_char(8'hFF);
    send_char(8'h00);
    send_text("12");
    send_char(CH_BS);
    send_char(CH_CTRLC);
    send_char(CH_LF);
    send_char(CH_LF);
    wait_drained();

    run_phase(11, 78, 1'b0);
    run_phase(78, 11, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS hex_line_entry_parser_core");
    end else begin
      $display("FAIL hex_line_entry_parser_core");
    end
    $finish;
  end

endmodule

// ===== hex_line_entry_parser_core.f =====
+incdir+rtl
rtl/hlep_pkg.sv
rtl/hlep_char_if.sv
rtl/hlep_result_if.sv
rtl/hlep_digit_buf.sv
rtl/hex_line_entry_parser_core.sv
tb/hlep_result_checker.sv
tb/hex_line_entry_parser_core_tb.sv
